// ===== rtl/rss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

  localparam int ADDR_W      = 48;
  localparam int LEN_W       = 18;
  localparam int CLEN_W      = 13;
  localparam int DEV_W       = 4;
  localparam int NDEV_W      = 5;
  localparam int BLOCK_BYTES = 4096;
  localparam int BLK_BITS    = $clog2(BLOCK_BYTES);
  localparam int MAX_DEVICES = 16;
  localparam int MAX_CHUNKS  = 64;
  localparam int DQ_W        = ADDR_W - BLK_BITS;
  localparam int DIV_STEPS   = 6;
  localparam int DIV_STAGES  = DQ_W / DIV_STEPS;
  localparam int SPAN_W      = LEN_W + 1;
  localparam int CNT_W       = SPAN_W - BLK_BITS;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 1'd1;

  typedef struct packed {
    logic                err;
    logic                mode;
    logic [ADDR_W-1:0]   host;
    logic [LEN_W-1:0]    len;
    logic [BLK_BITS-1:0] inner;
    logic [NDEV_W-1:0]   ndev;
    logic [DEV_W-1:0]    rem;
    logic [DQ_W-1:0]     dq;
  } rss_item_t;

endpackage

`default_nettype wire

// ===== rtl/rss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rss_front (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          adv,
  input  wire                          req_valid,
  input  wire                          mode,
  input  wire [rss_pkg::ADDR_W-1:0]    array_offset,
  input  wire [rss_pkg::ADDR_W-1:0]    host_addr,
  input  wire [rss_pkg::LEN_W-1:0]     request_length,
  input  wire [rss_pkg::NDEV_W-1:0]    device_count,
  input  wire [rss_pkg::ADDR_W-1:0]    region_base,
  output logic                         out_valid,
  output rss_pkg::rss_item_t           out_item
);
  import rss_pkg::*;

  logic [NDEV_W-1:0] ndev;
  logic [ADDR_W-1:0] off;
  logic [SPAN_W-1:0] span;
  logic [CNT_W-1:0]  chunks;
  logic              below;
  rss_item_t         item_next;

  always_comb begin
    if (device_count == '0) begin
      ndev = NDEV_W'(1);
    end else if (device_count > NDEV_W'(MAX_DEVICES)) begin
      ndev = NDEV_W'(MAX_DEVICES);
    end else begin
      ndev = device_count;
    end
    below  = array_offset < region_base;
    off    = array_offset - region_base;
    span   = {{(SPAN_W-BLK_BITS){1'b0}}, off[BLK_BITS-1:0]} + {1'b0, request_length}
             + SPAN_W'(BLOCK_BYTES - 1);
    chunks = span[SPAN_W-1:BLK_BITS];
    item_next.err   = below || (chunks > CNT_W'(MAX_CHUNKS));
    item_next.mode  = mode;
    item_next.host  = host_addr;
    item_next.len   = request_length;
    item_next.inner = off[BLK_BITS-1:0];
    item_next.ndev  = ndev;
    item_next.rem   = '0;
    item_next.dq    = off[ADDR_W-1:BLK_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= req_valid && (request_length != '0);
    end
    if (adv) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rss_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rss_div_stage (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      adv,
  input  wire                      in_valid,
  input  wire rss_pkg::rss_item_t  in_item,
  output logic                     out_valid,
  output rss_pkg::rss_item_t       out_item
);
  import rss_pkg::*;

  rss_item_t         item_next;
  logic [NDEV_W-1:0] trial;
  logic [NDEV_W-1:0] diff;

  // Restoring division of the block number by the device count, six quotient bits per stage.
  always_comb begin
    item_next = in_item;
    trial     = '0;
    diff      = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial        = {item_next.rem, item_next.dq[DQ_W-1]};
      item_next.dq = {item_next.dq[DQ_W-2:0], 1'b0};
      if (trial >= item_next.ndev) begin
        diff            = trial - item_next.ndev;
        item_next.rem   = diff[DEV_W-1:0];
        item_next.dq[0] = 1'b1;
      end else begin
        item_next.rem   = trial[DEV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rss_chunker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rss_chunker (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  input  wire rss_pkg::rss_item_t      in_item,
  output logic                         in_ready,
  output logic                         chunk_valid,
  input  wire                          chunk_ready,
  output logic [rss_pkg::DEV_W-1:0]    device_index,
  output logic [rss_pkg::ADDR_W-1:0]   device_offset,
  output logic [rss_pkg::CLEN_W-1:0]   chunk_length,
  output logic [rss_pkg::ADDR_W-1:0]   chunk_host_addr,
  output logic                         direction,
  output logic                         last_chunk,
  output logic                         error
);
  import rss_pkg::*;

  logic                busy;
  logic                err;
  logic                mode;
  logic [DEV_W-1:0]    dev;
  logic [DQ_W-1:0]     row;
  logic [BLK_BITS-1:0] inner;
  logic [ADDR_W-1:0]   host;
  logic [LEN_W-1:0]    rem_len;
  logic [NDEV_W-1:0]   ndev;

  logic [CLEN_W-1:0]   room;
  logic                last;
  logic [CLEN_W-1:0]   take;
  logic [NDEV_W-1:0]   dev_inc;
  logic                emit;

  always_comb begin
    room     = CLEN_W'(BLOCK_BYTES) - {{(CLEN_W-BLK_BITS){1'b0}}, inner};
    last     = rem_len <= {{(LEN_W-CLEN_W){1'b0}}, room};
    take     = last ? rem_len[CLEN_W-1:0] : room;
    dev_inc  = {1'b0, dev} + NDEV_W'(1);
    emit     = busy && (!chunk_valid || chunk_ready);
    in_ready = !busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      chunk_valid <= 1'b0;
    end else begin
      if (emit) begin
        chunk_valid <= 1'b1;
      end else if (chunk_ready) begin
        chunk_valid <= 1'b0;
      end
      if (!busy && in_valid) begin
        busy <= 1'b1;
      end else if (emit && (err || last)) begin
        busy <= 1'b0;
      end
    end

    if (!busy && in_valid) begin
      err     <= in_item.err;
      mode    <= in_item.mode;
      dev     <= in_item.rem;
      row     <= in_item.dq;
      inner   <= in_item.inner;
      host    <= in_item.host;
      rem_len <= in_item.len;
      ndev    <= in_item.ndev;
    end else if (emit) begin
      direction  <= mode;
      last_chunk <= err || last;
      error      <= err;
      if (err) begin
        device_index    <= '0;
        device_offset   <= '0;
        chunk_length    <= '0;
        chunk_host_addr <= '0;
      end else begin
        device_index    <= dev;
        device_offset   <= {row, inner};
        chunk_length    <= take;
        chunk_host_addr <= host;
      end
      if (!err && !last) begin
        inner   <= '0;
        rem_len <= rem_len - {{(LEN_W-CLEN_W){1'b0}}, room};
        host    <= host + {{(ADDR_W-CLEN_W){1'b0}}, room};
        if (dev_inc == ndev) begin
          dev <= '0;
          row <= row + DQ_W'(1);
        end else begin
          dev <= dev_inc[DEV_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/raid0_stripe_splitter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                Beat contents
// req       req_valid / req_ready    mode, array_offset, host_addr, request_length
// chunk     chunk_valid / chunk_ready  device_index, device_offset, chunk_length,
//                                    chunk_host_addr, direction, last_chunk, error
// cfg       cfg_we                   cfg_index, cfg_data
//
// A request passes a check stage and six divider stages (block number over device
// count), then the chunker, before its first beat can show.
// The chunker loads a request, then emits one beat per cycle unless chunk_ready
// holds it back; it takes no new request until the last beat, and an error request
// gives a single beat. Requests of zero length are dropped in the check stage.
// The pipeline advances as a whole and holds only while the chunker is busy and the
// last divider stage holds a request; reset is synchronous and sets only the valid
// bits, the busy flag and the config (device count to one, region base to zero).

module raid0_stripe_splitter_unit (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [rss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [rss_pkg::ADDR_W-1:0]    cfg_data,
  input  wire                          req_valid,
  output logic                         req_ready,
  input  wire                          mode,
  input  wire [rss_pkg::ADDR_W-1:0]    array_offset,
  input  wire [rss_pkg::ADDR_W-1:0]    host_addr,
  input  wire [rss_pkg::LEN_W-1:0]     request_length,
  output logic                         chunk_valid,
  input  wire                          chunk_ready,
  output logic [rss_pkg::DEV_W-1:0]    device_index,
  output logic [rss_pkg::ADDR_W-1:0]   device_offset,
  output logic [rss_pkg::CLEN_W-1:0]   chunk_length,
  output logic [rss_pkg::ADDR_W-1:0]   chunk_host_addr,
  output logic                         direction,
  output logic                         last_chunk,
  output logic                         error
);
  import rss_pkg::*;

  logic [NDEV_W-1:0]   device_count;
  logic [ADDR_W-1:0]   region_base;
  logic                adv;
  logic                ck_ready;
  logic [DIV_STAGES:0] stage_valid;
  rss_item_t           stage_item [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      device_count <= NDEV_W'(1);
      region_base  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEVICE_COUNT: device_count <= cfg_data[NDEV_W-1:0];
        REG_REGION_BASE:  region_base  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign adv       = !stage_valid[DIV_STAGES] || ck_ready;
  assign req_ready = adv;

  rss_front u_front (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .req_valid      (req_valid),
    .mode           (mode),
    .array_offset   (array_offset),
    .host_addr      (host_addr),
    .request_length (request_length),
    .device_count   (device_count),
    .region_base    (region_base),
    .out_valid      (stage_valid[0]),
    .out_item       (stage_item[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    rss_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (stage_valid[g]),
      .in_item   (stage_item[g]),
      .out_valid (stage_valid[g+1]),
      .out_item  (stage_item[g+1])
    );
  end

  rss_chunker u_chunker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (stage_valid[DIV_STAGES]),
    .in_item         (stage_item[DIV_STAGES]),
    .in_ready        (ck_ready),
    .chunk_valid     (chunk_valid),
    .chunk_ready     (chunk_ready),
    .device_index    (device_index),
    .device_offset   (device_offset),
    .chunk_length    (chunk_length),
    .chunk_host_addr (chunk_host_addr),
    .direction       (direction),
    .last_chunk      (last_chunk),
    .error           (error)
  );

endmodule

`default_nettype wire
